### rtl/core/hsd_pkg.sv
// Shared types, constants and jamo tables for the Hangul syllable decomposer.
package hsd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned OFS_W = 14;   // syllable offset, 0..11171
  localparam int unsigned QUO_W = 9;    // offset / 28, 0..398

  localparam logic [CP_W-1:0] SYL_FIRST = 21'h00AC00;
  localparam logic [CP_W-1:0] SYL_LAST  = 21'h00D7A3;

  // reciprocals: q = (s * RECIP_28) >> 18, i = (q * RECIP_21) >> 14, exact over the ranges
  localparam logic [13:0] RECIP_28 = 14'd9363;
  localparam logic [9:0]  RECIP_21 = 10'd781;

  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_INITIAL = 2'd1;
  localparam logic [1:0] MODE_MEDIAL  = 2'd2;

  // one classified input item as it sits in the queue
  typedef struct packed {
    logic             pass;   // not a syllable: emit cp as is
    logic [CP_W-1:0]  cp;
    logic [IDX_W-1:0] ini;
    logic [IDX_W-1:0] med;
    logic [IDX_W-1:0] fin;
  } hsd_item_t;

  function automatic logic [15:0] initial_jamo(input logic [IDX_W-1:0] idx);
    logic [15:0] r;
    unique case (idx)
      5'd0:  r = 16'h3131;
      5'd1:  r = 16'h3132;
      5'd2:  r = 16'h3134;
      5'd3:  r = 16'h3137;
      5'd4:  r = 16'h3138;
      5'd5:  r = 16'h3139;
      5'd6:  r = 16'h3141;
      5'd7:  r = 16'h3142;
      5'd8:  r = 16'h3143;
      5'd9:  r = 16'h3145;
      5'd10: r = 16'h3146;
      5'd11: r = 16'h3147;
      5'd12: r = 16'h3148;
      5'd13: r = 16'h3149;
      5'd14: r = 16'h314A;
      5'd15: r = 16'h314B;
      5'd16: r = 16'h314C;
      5'd17: r = 16'h314D;
      default: r = 16'h314E;  // index 18 and above
    endcase
    return r;
  endfunction

  function automatic logic [15:0] medial_jamo(input logic [IDX_W-1:0] idx);
    logic [15:0] r;
    unique case (idx)
      5'd0:  r = 16'h314F;
      5'd1:  r = 16'h3150;
      5'd2:  r = 16'h3151;
      5'd3:  r = 16'h3152;
      5'd4:  r = 16'h3153;
      5'd5:  r = 16'h3154;
      5'd6:  r = 16'h3155;
      5'd7:  r = 16'h3156;
      5'd8:  r = 16'h3157;
      5'd9:  r = 16'h3158;
      5'd10: r = 16'h3159;
      5'd11: r = 16'h315A;
      5'd12: r = 16'h315B;
      5'd13: r = 16'h315C;
      5'd14: r = 16'h315D;
      5'd15: r = 16'h315E;
      5'd16: r = 16'h315F;
      5'd17: r = 16'h3160;
      5'd18: r = 16'h3161;
      5'd19: r = 16'h3162;
      default: r = 16'h3163;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] final_jamo(input logic [IDX_W-1:0] idx);
    logic [15:0] r;
    unique case (idx)
      5'd1:  r = 16'h3131;
      5'd2:  r = 16'h3132;
      5'd3:  r = 16'h3133;
      5'd4:  r = 16'h3134;
      5'd5:  r = 16'h3135;
      5'd6:  r = 16'h3136;
      5'd7:  r = 16'h3137;
      5'd8:  r = 16'h3139;
      5'd9:  r = 16'h313A;
      5'd10: r = 16'h313B;
      5'd11: r = 16'h313C;
      5'd12: r = 16'h313D;
      5'd13: r = 16'h313E;
      5'd14: r = 16'h313F;
      5'd15: r = 16'h3140;
      5'd16: r = 16'h3141;
      5'd17: r = 16'h3142;
      5'd18: r = 16'h3144;
      5'd19: r = 16'h3145;
      5'd20: r = 16'h3146;
      5'd21: r = 16'h3147;
      5'd22: r = 16'h3148;
      5'd23: r = 16'h314A;
      5'd24: r = 16'h314B;
      5'd25: r = 16'h314C;
      5'd26: r = 16'h314D;
      5'd27: r = 16'h314E;
      default: r = 16'h0000;  // no final
    endcase
    return r;
  endfunction

endpackage

### rtl/core/hangul_syllable_decomposer_unit.sv
// A code point accepted at the input passes the front stages and the queue before its first result shows on m_tvalid.
// Throughput: one result per cycle unless the queue is empty or m_tready stalls; a full-mode syllable yields
//   three results (two with no final), any other item one result. The single output register sets this rate.
// The front end takes one code point per cycle while the queue has room.
// Reset (rst, synchronous, active high) empties pipeline and queue, drops m_tvalid,
//   and sets mode to full decomposition.
module hangul_syllable_decomposer_unit
  import hsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // mode register write
  input  logic        mode_we,
  input  logic [1:0]  mode_wdata,
  // input code points
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  // emitted code points
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] out_code_point, [23:21] zero
  output logic        m_tlast    // last result caused by one request
);

  logic [1:0]      mode_reg;
  hsd_item_t       push_item;
  hsd_item_t       head_item;
  logic            push;
  logic            push_ready;
  logic            head_valid;
  logic            pop;
  logic [CP_W-1:0] out_cp;

  // the user must see that mode changes only while the block is idle; it is not enforced. Back end reads it directly
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_FULL;
    end else if (mode_we) begin
      mode_reg <= mode_wdata;
    end
  end

  // front: capture, offset, reciprocal divides by 28 and 21
  hsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cp      (s_tdata[CP_W-1:0]),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue: front keeps running while results drain
  hsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head_item  (head_item)
  );

  // back: one jamo per cycle into the output register while m_tready does not stall it
  hsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode_reg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cp     (out_cp),
    .out_last   (m_tlast)
  );

  assign m_tdata = {3'd0, out_cp};

endmodule

### rtl/core/hsd_front.sv
// Front end: accepts code points, classifies them and splits syllables into indices.
module hsd_front
  import hsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] in_cp,
  output logic            push,
  input  logic            push_ready,
  output hsd_item_t       push_item
);

  // stage 1: captured input
  logic            v1;
  logic [CP_W-1:0] cp1;
  // stage 2: offset and quotient by 28
  logic             v2;
  logic [CP_W-1:0]  cp2;
  logic             syl2;
  logic [OFS_W-1:0] ofs2;
  logic [QUO_W-1:0] quo2;
  // stage 3: initial and final indices
  logic             v3;
  logic [CP_W-1:0]  cp3;
  logic             syl3;
  logic [QUO_W-1:0] quo3;
  logic [IDX_W-1:0] ini3;
  logic [IDX_W-1:0] fin3;

  logic             adv;
  logic [OFS_W-1:0] diff1;
  logic [27:0]      prod28;
  logic [18:0]      prod21;
  logic [OFS_W-1:0] quo_x28;
  logic [OFS_W-1:0] fin_full;
  logic [QUO_W-1:0] ini_x21;
  logic [QUO_W-1:0] med_full;

  assign adv      = !v3 || push_ready;
  assign in_ready = adv;

  assign diff1  = cp1[OFS_W-1:0] - SYL_FIRST[OFS_W-1:0];
  assign prod28 = {14'd0, diff1} * {14'd0, RECIP_28};

  assign prod21   = {10'd0, quo2} * {9'd0, RECIP_21};
  assign quo_x28  = {quo2, 5'd0} - {3'd0, quo2, 2'd0};
  assign fin_full = ofs2 - quo_x28;

  assign ini_x21  = {ini3, 4'd0} + {2'd0, ini3, 2'd0} + {4'd0, ini3};
  assign med_full = quo3 - ini_x21;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp1  <= in_cp;
      cp2  <= cp1;
      syl2 <= (cp1 >= SYL_FIRST) && (cp1 <= SYL_LAST);
      ofs2 <= diff1;
      quo2 <= prod28[QUO_W+17:18];
      cp3  <= cp2;
      syl3 <= syl2;
      quo3 <= quo2;
      ini3 <= prod21[IDX_W+13:14];
      fin3 <= fin_full[IDX_W-1:0];
    end
  end

  assign push           = v3;
  assign push_item.pass = !syl3;
  assign push_item.cp   = cp3;
  assign push_item.ini  = ini3;
  assign push_item.med  = med_full[IDX_W-1:0];
  assign push_item.fin  = fin3;

endmodule

### rtl/core/hsd_queue.sv
// Small FIFO that decouples the classifying front end from the emitting back end.
module hsd_queue
  import hsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      push_ready,
  input  hsd_item_t push_item,
  output logic      head_valid,
  input  logic      pop,
  output hsd_item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hsd_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/hsd_back.sv
// Back end: walks each queued item through its jamo and drives the output register.
module hsd_back
  import hsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      mode,
  input  logic            head_valid,
  input  hsd_item_t       head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_cp,
  output logic            out_last
);

  logic [1:0]      phase;
  logic [1:0]      phase_next;
  logic            load;
  logic [CP_W-1:0] res_cp;
  logic            res_last;

  always_comb begin
    res_cp   = head_item.cp;
    res_last = 1'b1;
    if (!head_item.pass) begin
      priority case (1'b1)
        mode == MODE_INITIAL: res_cp = {5'd0, initial_jamo(head_item.ini)};
        mode == MODE_MEDIAL:  res_cp = {5'd0, medial_jamo(head_item.med)};
        phase == 2'd0: begin
          res_cp   = {5'd0, initial_jamo(head_item.ini)};
          res_last = 1'b0;
        end
        phase == 2'd1: begin
          res_cp   = {5'd0, medial_jamo(head_item.med)};
          res_last = (head_item.fin == '0);
        end
        default: res_cp = {5'd0, final_jamo(head_item.fin)};
      endcase
    end
  end

  assign load       = head_valid && (!out_valid || out_ready);
  assign pop        = load && res_last;
  assign phase_next = res_last ? 2'd0 : phase + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase <= phase_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp   <= res_cp;
      out_last <= res_last;
    end
  end

endmodule

### rtl/core/hsd_checker.sv
// Port-level checker for the decomposer, bound to the top level.
module hsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] == 3'd0))
    else $error("tdata padding not zero");

  // only a syllable yields several results, and those before the last are jamo
  a_mid_jamo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[20:0] >= 21'h3131) && (m_tdata[20:0] <= 21'h3163))
    else $error("non-last result is not a jamo");

endmodule

bind hangul_syllable_decomposer_unit hsd_checker u_hsd_checker (.*);

### bench/tb_top.sv
// Self-checking bench for the Hangul syllable decomposer: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
  import hsd_pkg::*;

  // mode 3 has no name in the package; the block treats it as full decomposition
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // cycles with no handshake on either side before the run is called hung
  localparam int unsigned STALL_LIMIT = 3000;
  // first result follows acceptance through the front stages and the queue; leave a little margin
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        mode_we;
  logic [1:0]  mode_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [20:0] code_point, [23:21] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;    // [20:0] out_code_point, [23:21] zero
  logic        m_tlast;

  // one emitted code point as the checker expects it
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } jamo_t;

  // directed request: mode to run it under, input, and up to three typed-in results
  // (n_typed == 0 means the decomposition predictor supplies the expectation)
  typedef struct packed {
    logic [1:0]           mode;
    logic [CP_W-1:0]      cp;
    logic [1:0]           n_typed;
    logic [2:0][CP_W-1:0] typed;
  } dir_row_t;

  jamo_t       jamo_due_q[$];
  dir_row_t    dir_tab[$];
  logic [1:0]  cur_mode;
  bit          send_calm;
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  int unsigned req_sent;

  // compatibility jamo for each index; final index 0 is "no final"
  logic [15:0] lead_tab [19] = '{
    16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141, 16'h3142,
    16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149, 16'h314A, 16'h314B,
    16'h314C, 16'h314D, 16'h314E
  };
  logic [15:0] vowel_tab [21] = '{
    16'h314F, 16'h3150, 16'h3151, 16'h3152, 16'h3153, 16'h3154, 16'h3155, 16'h3156,
    16'h3157, 16'h3158, 16'h3159, 16'h315A, 16'h315B, 16'h315C, 16'h315D, 16'h315E,
    16'h315F, 16'h3160, 16'h3161, 16'h3162, 16'h3163
  };
  logic [15:0] tail_tab [28] = '{
    16'h0000, 16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136, 16'h3137,
    16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E, 16'h313F, 16'h3140,
    16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h314A,
    16'h314B, 16'h314C, 16'h314D, 16'h314E
  };

  hangul_syllable_decomposer_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected jamo for one request under the current mode, queued in emit order.
  function automatic void predict_decomposition(input logic [CP_W-1:0] cp);
    int unsigned ofs;
    int unsigned lead;
    int unsigned vowel;
    int unsigned tail;
    if (cp < SYL_FIRST || cp > SYL_LAST) begin
      jamo_due_q.push_back({cp, 1'b1});    // not a syllable: passes through alone
      return;
    end
    ofs   = 32'(cp) - 32'(SYL_FIRST);
    lead  = ofs / (21 * 28);
    vowel = (ofs / 28) % 21;
    tail  = ofs % 28;
    if (lead > 18) lead = 18;
    case (cur_mode)
      MODE_INITIAL: begin
        jamo_due_q.push_back({5'd0, lead_tab[lead], 1'b1});
      end
      MODE_MEDIAL: begin
        jamo_due_q.push_back({5'd0, vowel_tab[vowel], 1'b1});
      end
      default: begin
        // full decomposition (also the spare mode); the vowel closes a run with no final
        jamo_due_q.push_back({5'd0, lead_tab[lead], 1'b0});
        jamo_due_q.push_back({5'd0, vowel_tab[vowel], tail == 0});
        if (tail != 0) jamo_due_q.push_back({5'd0, tail_tab[tail], 1'b1});
      end
    endcase
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] mode, input logic [CP_W-1:0] cp,
                                       input logic [1:0] n, input logic [CP_W-1:0] a,
                                       input logic [CP_W-1:0] b, input logic [CP_W-1:0] c);
    dir_row_t r;
    r.mode    = mode;
    r.cp      = cp;
    r.n_typed = n;
    r.typed   = {c, b, a};
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a calm stretch.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Mostly real syllables, plus the range edges, the BMP and the whole 21-bit space.
  function automatic logic [CP_W-1:0] pick_code_point();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CP_W'(32'(SYL_FIRST) + $urandom_range(0, 11171));
    if (r < 60) return CP_W'($urandom_range(32'hABF0, 32'hAC0F));
    if (r < 65) return CP_W'($urandom_range(32'hD798, 32'hD7AF));
    if (r < 80) return CP_W'($urandom_range(0, 32'hFFFF));
    return CP_W'($urandom & 32'h1FFFFF);
  endfunction

  // Entered and left at a falling edge. valid is lowered only when a gap is taken,
  // so back-to-back requests keep it high without a drop in the same step.
  task automatic send_code_point(input logic [CP_W-1:0] cp);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, cp};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    req_sent++;
  endtask

  // Hold the sender until every expected jamo is out, then let the pipe settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (jamo_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    mode_we    <= 1'b1;
    mode_wdata <= m;
    @(negedge clk);
    mode_we    <= 1'b0;
    cur_mode   = m;
  endtask

  // Receiver: random stalls, mostly short with a few long, and calm stretches of no stall.
  initial begin
    int unsigned hold;
    int unsigned calm_left;
    int unsigned r;
    logic        rdy;
    hold      = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(149) == 0) calm_left = $urandom_range(20, 60);
      if (hold != 0) begin
        rdy = 1'b0;
        hold--;
      end else begin
        rdy = 1'b1;
        r = $urandom_range(99);
        if (calm_left == 0) begin
          if (r < 15) hold = $urandom_range(1, 3);
          else if (r < 18) hold = $urandom_range(8, 30);
        end
      end
      m_tready <= rdy;
    end
  end

  // Result checker: each handshake on the master side against the oldest expectation.
  always @(posedge clk) begin
    jamo_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (jamo_due_q.size() == 0) begin
        $error("unexpected result: out_code_point %h last_of_run %b", m_tdata[20:0], m_tlast);
        fail_cnt++;
      end else begin
        want = jamo_due_q.pop_front();
        if (m_tdata[20:0] !== want.cp) begin
          $error("out_code_point: expected %h, got %h", want.cp, m_tdata[20:0]);
          fail_cnt++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_tlast);
          fail_cnt++;
        end
        if (m_tdata[23:21] !== 3'b000) begin
          $error("m_tdata pad: expected %b, got %b", 3'b000, m_tdata[23:21]);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned phase_len;
    dir_row_t    row;
    rst         = 1'b1;
    mode_we     = 1'b0;
    mode_wdata  = MODE_FULL;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cur_mode    = MODE_FULL;
    send_calm   = 1'b0;
    fail_cnt    = 0;
    idle_cycles = 0;
    req_sent    = 0;

    // Directed table. The first block runs on the reset mode, no write before it.
    dir_tab.push_back(dir_row(MODE_FULL, 21'h000000, 1, 21'h000000, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h1FFFFF, 1, 21'h1FFFFF, 0, 0));  // past Unicode
    dir_tab.push_back(dir_row(MODE_FULL, 21'h10FFFF, 1, 21'h10FFFF, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00ABFF, 1, 21'h00ABFF, 0, 0));  // just below range
    // first syllable has no final: two jamo, vowel closes the run
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00AC00, 2, 21'h3131, 21'h314F, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00AC01, 3, 21'h3131, 21'h314F, 21'h3131));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00D7A3, 3, 21'h314E, 21'h3163, 21'h314E));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00D7A4, 1, 21'h00D7A4, 0, 0));  // just above range
    dir_tab.push_back(dir_row(MODE_FULL, 21'h155555, 1, 21'h155555, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h0AAAAA, 1, 21'h0AAAAA, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00D55C, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00AE00, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_INITIAL, 21'h00AC00, 1, 21'h3131, 0, 0));
    dir_tab.push_back(dir_row(MODE_INITIAL, 21'h00D7A3, 1, 21'h314E, 0, 0));
    dir_tab.push_back(dir_row(MODE_INITIAL, 21'h00D55C, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_INITIAL, 21'h000041, 1, 21'h000041, 0, 0));
    dir_tab.push_back(dir_row(MODE_MEDIAL, 21'h00AC00, 1, 21'h314F, 0, 0));
    dir_tab.push_back(dir_row(MODE_MEDIAL, 21'h00D7A3, 1, 21'h3163, 0, 0));
    dir_tab.push_back(dir_row(MODE_MEDIAL, 21'h00B098, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_MEDIAL, 21'h1FFFFF, 1, 21'h1FFFFF, 0, 0));
    // spare mode decomposes fully
    dir_tab.push_back(dir_row(MODE_SPARE, 21'h00AC01, 3, 21'h3131, 21'h314F, 21'h3131));
    dir_tab.push_back(dir_row(MODE_SPARE, 21'h00AC00, 2, 21'h3131, 21'h314F, 0));
    dir_tab.push_back(dir_row(MODE_SPARE, 21'h00D55C, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_FULL, 21'h00D7A3, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      // mode only changes with the pipe empty
      if (row.mode != cur_mode) begin
        wait_drained();
        write_mode(row.mode);
      end
      if (row.n_typed == 0) begin
        predict_decomposition(row.cp);
      end else begin
        for (k = 0; k < row.n_typed; k++)
          jamo_due_q.push_back({row.typed[k], k == row.n_typed - 1});
      end
      send_code_point(row.cp);
    end

    // Random phases: drain, pick a mode, then a run of requests, some of them gap-free.
    while (req_sent < 145) begin
      wait_drained();
      write_mode(2'($urandom_range(0, 3)));
      phase_len = $urandom_range(15, 40);
      send_calm = ($urandom_range(3) == 0);
      for (k = 0; k < phase_len; k++) begin
        row.cp = pick_code_point();
        predict_decomposition(row.cp);
        send_code_point(row.cp);
      end
    end
    send_calm = 1'b0;

    wait_drained();
    if (jamo_due_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
